// ===== sv/tpsb_pkg.sv =====
// Shared types and constants for the tree path and scope builder.
package tpsb_pkg;

  localparam int MaxDepthDef   = 32;
  localparam int MaxTreeLenDef = 256;
  localparam int LabelBitsDef  = 16;

  localparam int LabelW = 16;
  localparam int PosW   = 9;
  localparam int SlotW  = 14;
  localparam int RankW  = 8;

  typedef enum logic [1:0] {
    KIND_PATH  = 2'd0,
    KIND_MARK  = 2'd1,
    KIND_SCOPE = 2'd2,
    KIND_LEN   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PATH,
    ST_MARK,
    ST_SCOPE,
    ST_LEN,
    ST_NOTE
  } state_e;

  typedef struct packed {
    kind_e              kind;
    logic [LabelW-1:0]  label;
    logic [PosW-1:0]    pos;
    logic [SlotW-1:0]   slot;
    logic [RankW-1:0]   scope_begin;
    logic [RankW-1:0]   scope_end;
    logic               ovf;
    logic               last;
  } res_t;

endpackage

// ===== sv/tree_path_and_scope_builder.sv =====
// Top level: token sequencer, stack memory and output register.
// The first result item reaches m_axis through the state register and then the output register.
// A token that causes no result leaves the sequencer ready for the next token; otherwise
// the next token waits until all results are taken, the path walk reading one stack
// entry per cycle from the memory read port while m_axis does not stall.
// Reset: rst_ni clears the stack count, counters and output valid; stack memory is not cleared.
module tree_path_and_scope_builder #(
  parameter int MAX_DEPTH    = tpsb_pkg::MaxDepthDef,
  parameter int MAX_TREE_LEN = tpsb_pkg::MaxTreeLenDef,
  parameter int LABEL_BITS   = tpsb_pkg::LabelBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] node_label
  input  logic [0:0]  s_axis_tuser,   // [0] is_backtrack
  input  logic        s_axis_tlast,   // end_of_tree
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // label_out, token_position, path_slot,
                                      // scope_begin, scope_end, depth_overflow
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast    // last_of_run
);

  localparam int AW = $clog2(MAX_DEPTH);
  localparam int LW = (LABEL_BITS < tpsb_pkg::LabelW) ? LABEL_BITS : tpsb_pkg::LabelW;
  localparam int DW = LW + tpsb_pkg::PosW + tpsb_pkg::RankW;

  tpsb_pkg::res_t res, res_out;
  logic           res_valid, res_ready;
  logic           we;
  logic [AW-1:0]  waddr, raddr;
  logic [DW-1:0]  wdata, rdata;

  tpsb_ctrl #(
    .MaxDepth   (MAX_DEPTH),
    .MaxTreeLen (MAX_TREE_LEN),
    .LabelBits  (LABEL_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_bt_i     (s_axis_tuser[0]),
    .in_label_i  (s_axis_tdata),
    .in_end_i    (s_axis_tlast),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .raddr_o     (raddr),
    .rdata_i     (rdata)
  );

  tpsb_stack_ram #(
    .Depth (MAX_DEPTH),
    .DataW (DW)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  tpsb_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (res_valid),
    .ready_o (res_ready),
    .res_i   (res),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res_out)
  );

  assign m_axis_tdata = {res_out.ovf, res_out.scope_end, res_out.scope_begin,
                         res_out.slot, res_out.pos, res_out.label};
  assign m_axis_tuser = res_out.kind;
  assign m_axis_tlast = res_out.last;

endmodule

// ===== sv/tpsb_stack_ram.sv =====
// Stack memory of open nodes, one write and one registered read port.
module tpsb_stack_ram #(
  parameter int Depth = tpsb_pkg::MaxDepthDef,
  parameter int DataW = 33
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [DataW-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [DataW-1:0]         rdata_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // same-cycle write to the read address is forwarded
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/tpsb_ctrl.sv =====
// Token sequencer: stack bookkeeping, path walk and result generation.
module tpsb_ctrl #(
  parameter int MaxDepth   = tpsb_pkg::MaxDepthDef,
  parameter int MaxTreeLen = tpsb_pkg::MaxTreeLenDef,
  parameter int LabelBits  = tpsb_pkg::LabelBitsDef,
  localparam int AW = $clog2(MaxDepth),
  localparam int LW = (LabelBits < tpsb_pkg::LabelW) ? LabelBits : tpsb_pkg::LabelW,
  localparam int DW = LW + tpsb_pkg::PosW + tpsb_pkg::RankW
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          in_bt_i,
  input  logic [tpsb_pkg::LabelW-1:0]   in_label_i,
  input  logic                          in_end_i,
  output tpsb_pkg::res_t                res_o,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic                          we_o,
  output logic [AW-1:0]                 waddr_o,
  output logic [DW-1:0]                 wdata_o,
  output logic [AW-1:0]                 raddr_o,
  input  logic [DW-1:0]                 rdata_i
);

  localparam int CW = $clog2(MaxDepth + 1);
  localparam int TW = $clog2(MaxTreeLen + 1);

  tpsb_pkg::state_e state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [TW-1:0]    tok_q, tok_d;
  logic [7:0]       rank_q, rank_d;
  logic             rank_vld_q, rank_vld_d;
  logic             pwb_q, pwb_d;
  logic [13:0]      pc_q, pc_d;
  logic [AW-1:0]    idx_q, idx_d;
  logic [CW-1:0]    len_q, len_d;
  logic             end_q, end_d;
  logic             bt_q, bt_d;
  logic             ovf_q, ovf_d;

  logic          accept, fire, is_full, push, pop, idx_last;
  logic [TW-1:0] pos_sat;
  logic [7:0]    rank_inc, cur_rank;
  logic [CW-1:0] cnt_dec;
  logic [AW-1:0] top;
  logic [13:0]   slot_next;
  logic [LW-1:0] rd_label;
  logic [8:0]    rd_pos;
  logic [7:0]    rd_rank;

  assign in_ready_o = (state_q == tpsb_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign fire       = res_valid_o && res_ready_i;

  assign pos_sat  = (tok_q == TW'(MaxTreeLen)) ? tok_q : tok_q + TW'(1);
  assign is_full  = (cnt_q == CW'(MaxDepth));
  assign push     = !in_bt_i && !is_full;
  assign pop      = in_bt_i && (cnt_q != '0);
  assign rank_inc = rank_vld_q ? ((rank_q == 8'hFF) ? rank_q : rank_q + 8'd1) : 8'd0;
  assign cur_rank = rank_vld_q ? rank_q : 8'd0;
  assign cnt_dec  = cnt_q - CW'(1);
  assign top      = cnt_dec[AW-1:0];
  assign slot_next = (pc_q == '1) ? pc_q : pc_q + 14'd1;
  assign idx_last = ((CW'(idx_q) + CW'(1)) == len_q);

  assign rd_label = rdata_i[LW-1:0];
  assign rd_pos   = rdata_i[LW+8:LW];
  assign rd_rank  = rdata_i[LW+16:LW+9];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tpsb_pkg::ST_IDLE: begin
        if (accept) begin
          if (!in_bt_i) begin
            if (in_end_i)   state_d = tpsb_pkg::ST_PATH;
            else if (!push) state_d = tpsb_pkg::ST_NOTE;
          end else if (pop && !pwb_q) begin
            state_d = tpsb_pkg::ST_PATH;
          end else if (pop) begin
            state_d = tpsb_pkg::ST_SCOPE;
          end else if (in_end_i) begin
            state_d = tpsb_pkg::ST_LEN;
          end
        end
      end
      tpsb_pkg::ST_PATH: begin
        if (fire && idx_last) state_d = bt_q ? tpsb_pkg::ST_MARK : tpsb_pkg::ST_LEN;
      end
      tpsb_pkg::ST_MARK, tpsb_pkg::ST_SCOPE: begin
        if (fire) state_d = end_q ? tpsb_pkg::ST_LEN : tpsb_pkg::ST_IDLE;
      end
      tpsb_pkg::ST_LEN, tpsb_pkg::ST_NOTE: begin
        if (fire) state_d = tpsb_pkg::ST_IDLE;
      end
      default: state_d = tpsb_pkg::ST_IDLE;
    endcase
  end

  // outputs: result, memory ports
  always_comb begin
    res_o             = '0;
    res_o.ovf         = ovf_q;
    res_valid_o       = 1'b0;
    raddr_o           = idx_q;
    we_o              = accept && push;
    waddr_o           = cnt_q[AW-1:0];
    wdata_o           = {rank_inc, 9'(pos_sat), in_label_i[LW-1:0]};
    case (state_q)
      tpsb_pkg::ST_IDLE: begin
        // first path entry, or the top entry for a later pop
        raddr_o = (pop && pwb_q) ? top : '0;
      end
      tpsb_pkg::ST_PATH: begin
        res_valid_o = 1'b1;
        res_o.kind  = tpsb_pkg::KIND_PATH;
        res_o.label = tpsb_pkg::LabelW'(rd_label);
        res_o.pos   = rd_pos;
        res_o.slot  = slot_next;
        if (fire && !idx_last) raddr_o = idx_q + AW'(1);
      end
      tpsb_pkg::ST_MARK: begin
        res_valid_o       = 1'b1;
        res_o.kind        = tpsb_pkg::KIND_MARK;
        res_o.slot        = slot_next;
        res_o.scope_begin = rd_rank;
        res_o.scope_end   = cur_rank;
        res_o.last        = !end_q;
      end
      tpsb_pkg::ST_SCOPE: begin
        res_valid_o       = 1'b1;
        res_o.kind        = tpsb_pkg::KIND_SCOPE;
        res_o.pos         = rd_pos;
        res_o.scope_begin = rd_rank;
        res_o.scope_end   = cur_rank;
        res_o.last        = !end_q;
      end
      tpsb_pkg::ST_LEN: begin
        res_valid_o     = 1'b1;
        res_o.kind      = tpsb_pkg::KIND_LEN;
        res_o.pos       = (pc_q > 14'd511) ? 9'd511 : pc_q[8:0];
        res_o.scope_end = cur_rank;
        res_o.last      = 1'b1;
      end
      tpsb_pkg::ST_NOTE: begin
        // dropped push with nothing else to report
        res_valid_o = 1'b1;
        res_o.kind  = tpsb_pkg::KIND_MARK;
        res_o.last  = 1'b1;
      end
      default: ;
    endcase
  end

  // datapath registers
  always_comb begin
    cnt_d      = cnt_q;
    tok_d      = tok_q;
    rank_d     = rank_q;
    rank_vld_d = rank_vld_q;
    pwb_d      = pwb_q;
    pc_d       = pc_q;
    idx_d      = idx_q;
    len_d      = len_q;
    end_d      = end_q;
    bt_d       = bt_q;
    ovf_d      = ovf_q;
    if (accept) begin
      tok_d = pos_sat;
      end_d = in_end_i;
      bt_d  = in_bt_i;
      ovf_d = !in_bt_i && is_full;
      if (!in_bt_i) begin
        pwb_d = 1'b0;
        idx_d = '0;
        len_d = push ? cnt_q + CW'(1) : cnt_q;
        if (push) begin
          cnt_d      = cnt_q + CW'(1);
          rank_d     = rank_inc;
          rank_vld_d = 1'b1;
        end
      end else if (pop) begin
        cnt_d = cnt_dec;
        pwb_d = 1'b1;
        len_d = cnt_q;
        idx_d = pwb_q ? top : '0;
      end
    end
    if (fire && ((state_q == tpsb_pkg::ST_PATH) || (state_q == tpsb_pkg::ST_MARK))) begin
      pc_d = slot_next;
    end
    if (fire && (state_q == tpsb_pkg::ST_PATH) && !idx_last) begin
      idx_d = idx_q + AW'(1);
    end
    if (fire && (state_q == tpsb_pkg::ST_LEN)) begin
      cnt_d      = '0;
      tok_d      = '0;
      rank_d     = '0;
      rank_vld_d = 1'b0;
      pwb_d      = 1'b0;
      pc_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tpsb_pkg::ST_IDLE;
      cnt_q      <= '0;
      tok_q      <= '0;
      rank_q     <= '0;
      rank_vld_q <= 1'b0;
      pwb_q      <= 1'b0;
      pc_q       <= '0;
      idx_q      <= '0;
      len_q      <= '0;
      end_q      <= 1'b0;
      bt_q       <= 1'b0;
      ovf_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      tok_q      <= tok_d;
      rank_q     <= rank_d;
      rank_vld_q <= rank_vld_d;
      pwb_q      <= pwb_d;
      pc_q       <= pc_d;
      idx_q      <= idx_d;
      len_q      <= len_d;
      end_q      <= end_d;
      bt_q       <= bt_d;
      ovf_q      <= ovf_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MaxDepth))
    else $error("stack count above depth");

  a_idx_in_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tpsb_pkg::ST_PATH) |-> (CW'(idx_q) < len_q))
    else $error("path index past path length");

  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_o |-> (state_q == tpsb_pkg::ST_IDLE))
    else $error("stack write outside idle");

  a_tree_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (state_q == tpsb_pkg::ST_LEN)) |=> (cnt_q == '0) && (pc_q == '0) && !rank_vld_q)
    else $error("state not cleared after tree end");

endmodule

// ===== sv/tpsb_out_reg.sv =====
// Output register holding one result item toward the master side.
module tpsb_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  tpsb_pkg::res_t res_i,
  output logic           valid_o,
  input  logic           ready_i,
  output tpsb_pkg::res_t res_o
);

  logic           valid_q, valid_d;
  tpsb_pkg::res_t res_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
